// ----- rtl/sftfd_pkg.sv -----
// Shared types and constants for the load-cell conditioner.
// Used by the channel interfaces, the divider unit and the top level.
package sftfd_pkg;

  localparam int MAX_DEPTH  = 16;
  localparam int RING_AW    = $clog2(MAX_DEPTH);
  localparam int CNT_W      = 5;
  localparam int SUM_W      = 37;
  localparam int TACC_W     = 29;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_TARE = 2'd1;
  localparam logic [1:0] REQ_FLOW = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_DEPTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_THRESHOLD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_CONSECUTIVE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_TIMEOUT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE_TIMEOUT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_OK        = 3'd5;

  localparam logic [4:0]  RST_FILTER_DEPTH     = 5'd10;
  localparam logic [30:0] RST_FLOW_THRESHOLD   = 31'd256;
  localparam logic [7:0]  RST_FLOW_CONSECUTIVE = 8'd3;
  localparam logic [31:0] RST_FLOW_TIMEOUT     = 32'd2000;
  localparam logic [31:0] RST_STALE_TIMEOUT    = 32'd500;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [31:0]        now_ms;
    logic               sample_ready;
    logic signed [23:0] raw_sample;
    logic signed [31:0] grams_sample;
  } req_t;

  typedef struct packed {
    logic signed [31:0] filtered_grams;
    logic signed [31:0] last_grams;
    logic signed [31:0] last_delta;
    logic               flow_active;
    logic               flow_detected;
    logic               flow_timed_out;
    logic               stale;
    logic               taring;
    logic               tare_done;
    logic signed [23:0] tare_offset;
  } res_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [CNT_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/sftfd_req_if.sv -----
// Request channel: valid, ready and one request item per beat.
// Depends on sftfd_pkg for the payload type.
interface sftfd_req_if import sftfd_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/sftfd_res_if.sv -----
// Result channel: valid, ready and one result item per beat.
// Depends on sftfd_pkg for the payload type.
interface sftfd_res_if import sftfd_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/scale_filter_tare_flow_detect.sv -----
// Load-cell conditioner top level: tare averaging, moving-average weight filter,
// flow detection and staleness check. Uses sftfd_pkg, both channel interfaces and
// sftfd_div.
//
// One request is handled at a time and every request returns exactly one result
// beat. A weight sample, and the tare read that completes the tare average, go
// through the shared bit-serial divider that forms the average: a start, the
// quotient bits one by one over the 37-bit sum, the sign fix and the hand-back
// of the quotient. The sample ring is a 16-entry memory with one registered read
// port. A result waiting on the output register does not stop the next request
// from being taken. Writing filter_depth restarts the moving average.
module scale_filter_tare_flow_detect import sftfd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  sftfd_req_if.sink             req_ch,
  sftfd_res_if.source           res_ch
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_TARE,
    S_TCHK,
    S_PUSH,
    S_SUB,
    S_DELTA,
    S_FLOW,
    S_TMO,
    S_DIV,
    S_DWAIT,
    S_OUT
  } state_t;

  state_t state;

  logic [4:0]  filter_depth;
  logic [30:0] flow_threshold;
  logic [7:0]  flow_consecutive;
  logic [31:0] flow_timeout_ms;
  logic [31:0] stale_timeout_ms;
  logic        sensor_ok;

  req_t item;

  logic signed [31:0] sample_ring [MAX_DEPTH];
  logic signed [31:0] ring_rd;

  logic signed [SUM_W-1:0]  ring_sum;
  logic [CNT_W-1:0]         fill_count;
  logic [RING_AW-1:0]       write_slot;
  logic signed [31:0]       average_value;
  logic                     tare_busy;
  logic signed [TACC_W-1:0] tare_accum;
  logic [CNT_W-1:0]         tare_reads;
  logic                     have_previous;
  logic signed [31:0]       previous_sample;
  logic signed [31:0]       latest_reading;
  logic signed [31:0]       latest_delta;
  logic                     flow_armed;
  logic                     flow_found;
  logic                     flow_expired;
  logic [7:0]               rising_run;
  logic [31:0]              flow_start_ms;
  logic [31:0]              last_conversion_ms;
  logic                     stale_flag;
  logic                     tare_done;
  logic signed [23:0]       tare_offset;
  logic                     avg_pending;
  logic                     div_tare;
  logic [CNT_W-1:0]         div_divisor;

  logic res_valid;
  res_t res_data;

  logic [CNT_W-1:0]         depth_n;
  logic                     fill_lt;
  logic [RING_AW-1:0]       ring_addr;
  logic [CNT_W-1:0]         slot_inc;
  logic signed [32:0]       delta_full;
  logic signed [31:0]       delta_sat;
  logic [7:0]               need;
  logic [7:0]               rising_run_next;
  logic [31:0]              stale_age;
  logic [31:0]              flow_age;
  logic signed [TACC_W-1:0] tare_sum_next;
  logic [CNT_W-1:0]         fill_inc;

  div_req_t div_req;
  div_rsp_t div_rsp;

  sftfd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    if (filter_depth == '0) begin
      depth_n = CNT_W'(1);
    end else if (filter_depth > CNT_W'(MAX_DEPTH)) begin
      depth_n = CNT_W'(MAX_DEPTH);
    end else begin
      depth_n = filter_depth;
    end
  end

  assign fill_lt   = fill_count < depth_n;
  assign fill_inc  = fill_count + CNT_W'(1);
  assign ring_addr = fill_lt ? fill_count[RING_AW-1:0] : write_slot;
  assign slot_inc  = CNT_W'(write_slot) + CNT_W'(1);

  assign delta_full = 33'(item.grams_sample) - 33'(previous_sample);
  always_comb begin
    if (delta_full[32] != delta_full[31]) begin
      delta_sat = delta_full[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      delta_sat = delta_full[31:0];
    end
  end

  assign need = (flow_consecutive == '0) ? 8'd1 : flow_consecutive;
  always_comb begin
    if (latest_delta > $signed({1'b0, flow_threshold})) begin
      rising_run_next = (rising_run == 8'hff) ? rising_run : rising_run + 8'd1;
    end else begin
      rising_run_next = '0;
    end
  end

  assign stale_age     = item.now_ms - last_conversion_ms;
  assign flow_age      = item.now_ms - flow_start_ms;
  assign tare_sum_next = tare_accum + TACC_W'(item.raw_sample);

  assign div_req.start    = (state == S_DIV);
  assign div_req.dividend = div_tare ? SUM_W'(tare_accum) : ring_sum;
  assign div_req.divisor  = div_divisor;

  assign req_ch.ready = (state == S_IDLE);
  assign res_ch.valid = res_valid;
  assign res_ch.data  = res_data;

  always_ff @(posedge clk) begin
    if (state == S_PUSH) begin
      sample_ring[ring_addr] <= item.grams_sample;
    end
    ring_rd <= sample_ring[ring_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      filter_depth       <= RST_FILTER_DEPTH;
      flow_threshold     <= RST_FLOW_THRESHOLD;
      flow_consecutive   <= RST_FLOW_CONSECUTIVE;
      flow_timeout_ms    <= RST_FLOW_TIMEOUT;
      stale_timeout_ms   <= RST_STALE_TIMEOUT;
      sensor_ok          <= 1'b1;
      item               <= '0;
      ring_sum           <= '0;
      fill_count         <= '0;
      write_slot         <= '0;
      average_value      <= '0;
      tare_busy          <= 1'b0;
      tare_accum         <= '0;
      tare_reads         <= '0;
      have_previous      <= 1'b0;
      previous_sample    <= '0;
      latest_reading     <= '0;
      latest_delta       <= '0;
      flow_armed         <= 1'b0;
      flow_found         <= 1'b0;
      flow_expired       <= 1'b0;
      rising_run         <= '0;
      flow_start_ms      <= '0;
      last_conversion_ms <= '0;
      stale_flag         <= 1'b0;
      tare_done          <= 1'b0;
      tare_offset        <= '0;
      avg_pending        <= 1'b0;
      div_tare           <= 1'b0;
      div_divisor        <= CNT_W'(1);
      res_valid          <= 1'b0;
      res_data           <= '0;
    end else begin
      if (res_valid && res_ch.ready) begin
        res_valid <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FILTER_DEPTH: begin
            filter_depth  <= cfg_data[4:0];
            fill_count    <= '0;
            write_slot    <= '0;
            ring_sum      <= '0;
            average_value <= '0;
          end
          CFG_FLOW_THRESHOLD:   flow_threshold   <= cfg_data[30:0];
          CFG_FLOW_CONSECUTIVE: flow_consecutive <= cfg_data[7:0];
          CFG_FLOW_TIMEOUT:     flow_timeout_ms  <= cfg_data;
          CFG_STALE_TIMEOUT:    stale_timeout_ms <= cfg_data;
          CFG_SENSOR_OK:        sensor_ok        <= cfg_data[0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (req_ch.valid) begin
            item        <= req_ch.data;
            tare_done   <= 1'b0;
            tare_offset <= '0;
            avg_pending <= 1'b0;
            state       <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          unique case (item.req_type)
            REQ_TARE: begin
              tare_busy  <= 1'b1;
              tare_accum <= '0;
              tare_reads <= '0;
              state      <= S_OUT;
            end
            REQ_FLOW: begin
              flow_armed    <= 1'b1;
              flow_found    <= 1'b0;
              flow_expired  <= 1'b0;
              rising_run    <= '0;
              latest_delta  <= '0;
              flow_start_ms <= item.now_ms;
              have_previous <= 1'b0;
              state         <= S_OUT;
            end
            REQ_TICK: begin
              stale_flag <= sensor_ok && (stale_age > stale_timeout_ms);
              if (!sensor_ok || !item.sample_ready) begin
                state <= S_TMO;
              end else if (tare_busy) begin
                state <= S_TARE;
              end else begin
                state <= S_PUSH;
              end
            end
            default: state <= S_OUT;
          endcase
        end
        S_TARE: begin
          tare_accum         <= tare_sum_next;
          last_conversion_ms <= item.now_ms;
          if (tare_reads != '1) begin
            tare_reads <= tare_reads + CNT_W'(1);
          end
          state <= S_TCHK;
        end
        S_TCHK: begin
          if (tare_reads >= depth_n) begin
            div_tare    <= 1'b1;
            div_divisor <= tare_reads;
            state       <= S_DIV;
          end else begin
            state <= S_OUT;
          end
        end
        S_PUSH: begin
          last_conversion_ms <= item.now_ms;
          latest_reading     <= item.grams_sample;
          ring_sum           <= ring_sum + SUM_W'(item.grams_sample);
          avg_pending        <= 1'b1;
          div_tare           <= 1'b0;
          if (fill_lt) begin
            fill_count  <= fill_inc;
            div_divisor <= fill_inc;
            state       <= S_DELTA;
          end else begin
            write_slot  <= (slot_inc == depth_n) ? '0 : slot_inc[RING_AW-1:0];
            div_divisor <= depth_n;
            state       <= S_SUB;
          end
        end
        S_SUB: begin
          ring_sum <= ring_sum - SUM_W'(ring_rd);
          state    <= S_DELTA;
        end
        S_DELTA: begin
          if (!have_previous) begin
            latest_delta  <= '0;
            have_previous <= 1'b1;
          end else begin
            latest_delta <= delta_sat;
          end
          previous_sample <= item.grams_sample;
          state           <= S_FLOW;
        end
        S_FLOW: begin
          if (flow_armed && !flow_found) begin
            rising_run <= rising_run_next;
            if (rising_run_next >= need) begin
              flow_found <= 1'b1;
              flow_armed <= 1'b0;
            end
          end
          state <= S_TMO;
        end
        S_TMO: begin
          if (flow_armed && !flow_found && (flow_age >= flow_timeout_ms)) begin
            flow_expired <= 1'b1;
            flow_armed   <= 1'b0;
          end
          state <= avg_pending ? S_DIV : S_OUT;
        end
        S_DIV: begin
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_rsp.done) begin
            if (div_tare) begin
              tare_offset     <= div_rsp.quotient[23:0];
              tare_done       <= 1'b1;
              tare_busy       <= 1'b0;
              fill_count      <= '0;
              write_slot      <= '0;
              ring_sum        <= '0;
              average_value   <= '0;
              have_previous   <= 1'b0;
              previous_sample <= '0;
              latest_delta    <= '0;
              latest_reading  <= '0;
              rising_run      <= '0;
            end else begin
              average_value <= div_rsp.quotient[31:0];
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_valid || res_ch.ready) begin
            res_valid               <= 1'b1;
            res_data.filtered_grams <= average_value;
            res_data.last_grams     <= latest_reading;
            res_data.last_delta     <= latest_delta;
            res_data.flow_active    <= flow_armed;
            res_data.flow_detected  <= flow_found;
            res_data.flow_timed_out <= flow_expired;
            res_data.stale          <= stale_flag;
            res_data.taring         <= tare_busy;
            res_data.tare_done      <= tare_done;
            res_data.tare_offset    <= tare_offset;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/sftfd_div.sv -----
// Shared restoring divider, one quotient bit per cycle, truncating toward zero.
// Signed dividend of SUM_W bits over a small unsigned nonzero divisor; uses sftfd_pkg.
module sftfd_div import sftfd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic                 neg;
  logic [DIV_CNT_W-1:0] count;
  logic [SUM_W-1:0]     quo;
  logic [CNT_W-1:0]     rem;
  logic [CNT_W-1:0]     dvs;
  logic [CNT_W:0]       rem_shift;
  logic [CNT_W:0]       rem_diff;
  logic                 fits;

  assign rem_shift = {rem, quo[SUM_W-1]};
  assign rem_diff  = rem_shift - {1'b0, dvs};
  assign fits      = rem_shift >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      neg   <= 1'b0;
      count <= '0;
      quo   <= '0;
      rem   <= '0;
      dvs   <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        neg   <= req.dividend[SUM_W-1];
        quo   <= req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);
        rem   <= '0;
        dvs   <= req.divisor;
        count <= DIV_CNT_W'(SUM_W);
      end else if (busy) begin
        if (count != '0) begin
          rem   <= fits ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
          quo   <= {quo[SUM_W-2:0], fits};
          count <= count - DIV_CNT_W'(1);
        end else begin
          quo  <= neg ? SUM_W'(-quo) : quo;
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = $signed(quo);

endmodule

// ----- tb/sv/sftfd_reading_checker.sv -----
// Checker for the load-cell conditioner: watches the request, result and register ports,
// predicts every result beat from its own copy of the state and compares it field by field.
// Depends on sftfd_pkg and the two channel interfaces.
module sftfd_reading_checker import sftfd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  sftfd_req_if                  req_ch,
  sftfd_res_if                  res_ch,
  output int                    mismatch_count,
  output int                    outstanding
);

  localparam longint DELTA_MAX = 64'sd2147483647;
  localparam longint DELTA_MIN = -64'sd2147483648;

  logic [4:0]  depth_reg;
  logic [30:0] thresh_reg;
  logic [7:0]  run_need_reg;
  logic [31:0] flow_limit_ms;
  logic [31:0] stale_limit_ms;
  logic        sensor_good;

  longint      ring [MAX_DEPTH];
  longint      ring_total;
  int          filled;
  int          slot;
  longint      average;
  bit          taring_now;
  longint      tare_total;
  int          tare_count;
  bit          seen_sample;
  longint      prev_grams;
  longint      reading;
  longint      delta;
  bit          armed;
  bit          found;
  bit          expired;
  int          run_len;
  logic [31:0] armed_at_ms;
  logic [31:0] converted_at_ms;
  bit          stale_now;

  res_t        expected_readings [$];
  res_t        got_beat;
  res_t        want_beat;
  int          beats_seen;

  function automatic int depth_in_use();
    if (depth_reg < 1) return 1;
    if (depth_reg > MAX_DEPTH) return MAX_DEPTH;
    return int'(depth_reg);
  endfunction

  function automatic void restart_average();
    filled = 0;
    slot = 0;
    ring_total = 0;
    average = 0;
  endfunction

  function automatic void add_weight(longint g);
    int n;
    int s;
    n = depth_in_use();
    if (filled < n) begin
      ring[filled] = g;
      ring_total += g;
      filled++;
      average = ring_total / filled;
    end else begin
      s = slot % n;
      ring_total -= ring[s];
      ring[s] = g;
      ring_total += g;
      slot = (s + 1) % n;
      average = ring_total / n;
    end
  endfunction

  function automatic void check_flow_expiry(logic [31:0] now);
    logic [31:0] span;
    span = now - armed_at_ms;
    if (armed && !found && span >= flow_limit_ms) begin
      expired = 1'b1;
      armed = 1'b0;
    end
  endfunction

  function automatic void reset_model();
    depth_reg = RST_FILTER_DEPTH;
    thresh_reg = RST_FLOW_THRESHOLD;
    run_need_reg = RST_FLOW_CONSECUTIVE;
    flow_limit_ms = RST_FLOW_TIMEOUT;
    stale_limit_ms = RST_STALE_TIMEOUT;
    sensor_good = 1'b1;
    restart_average();
    taring_now = 1'b0;
    tare_total = 0;
    tare_count = 0;
    seen_sample = 1'b0;
    prev_grams = 0;
    reading = 0;
    delta = 0;
    armed = 1'b0;
    found = 1'b0;
    expired = 1'b0;
    run_len = 0;
    armed_at_ms = '0;
    converted_at_ms = '0;
    stale_now = 1'b0;
  endfunction

  function automatic void write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_FILTER_DEPTH: begin
        depth_reg = data[4:0];
        restart_average();
      end
      CFG_FLOW_THRESHOLD:   thresh_reg = data[30:0];
      CFG_FLOW_CONSECUTIVE: run_need_reg = data[7:0];
      CFG_FLOW_TIMEOUT:     flow_limit_ms = data;
      CFG_STALE_TIMEOUT:    stale_limit_ms = data;
      CFG_SENSOR_OK:        sensor_good = data[0];
      default: ;
    endcase
  endfunction

  function automatic res_t condition_request(req_t r);
    res_t        item;
    logic [31:0] now;
    logic [31:0] span;
    longint      raw;
    longint      grams;
    longint      offset;
    longint      diff;
    bit          finished;
    int          need;
    now = r.now_ms;
    raw = longint'($signed(r.raw_sample));
    grams = longint'($signed(r.grams_sample));
    offset = 0;
    finished = 1'b0;
    case (r.req_type)
      REQ_TARE: begin
        taring_now = 1'b1;
        tare_total = 0;
        tare_count = 0;
      end
      REQ_FLOW: begin
        armed = 1'b1;
        found = 1'b0;
        expired = 1'b0;
        run_len = 0;
        delta = 0;
        armed_at_ms = now;
        seen_sample = 1'b0;
      end
      REQ_TICK: begin
        span = now - converted_at_ms;
        stale_now = sensor_good && (span > stale_limit_ms);
        if (!sensor_good || !r.sample_ready) begin
          check_flow_expiry(now);
        end else if (taring_now) begin
          tare_total += raw;
          if (tare_count < 31) tare_count++;
          converted_at_ms = now;
          if (tare_count >= depth_in_use()) begin
            offset = tare_total / tare_count;
            finished = 1'b1;
            restart_average();
            seen_sample = 1'b0;
            prev_grams = 0;
            delta = 0;
            reading = 0;
            run_len = 0;
            taring_now = 1'b0;
          end
        end else begin
          need = (run_need_reg < 1) ? 1 : int'(run_need_reg);
          converted_at_ms = now;
          reading = grams;
          add_weight(grams);
          if (!seen_sample) begin
            delta = 0;
            seen_sample = 1'b1;
          end else begin
            diff = grams - prev_grams;
            if (diff > DELTA_MAX) diff = DELTA_MAX;
            if (diff < DELTA_MIN) diff = DELTA_MIN;
            delta = diff;
          end
          prev_grams = grams;
          if (armed && !found) begin
            if (delta > longint'(thresh_reg)) begin
              if (run_len < 255) run_len++;
            end else begin
              run_len = 0;
            end
            if (run_len >= need) begin
              found = 1'b1;
              armed = 1'b0;
            end
          end
          check_flow_expiry(now);
        end
      end
      default: ;
    endcase
    item.filtered_grams = average[31:0];
    item.last_grams = reading[31:0];
    item.last_delta = delta[31:0];
    item.flow_active = armed;
    item.flow_detected = found;
    item.flow_timed_out = expired;
    item.stale = stale_now;
    item.taring = taring_now;
    item.tare_done = finished;
    item.tare_offset = offset[23:0];
    return item;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at result beat %0d: %s", beats_seen, what);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_model();
      expected_readings.delete();
      mismatch_count <= 0;
      beats_seen <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) write_setting(cfg_index, cfg_data);
      if (req_ch.valid && req_ch.ready) begin
        expected_readings.push_back(condition_request(req_ch.data));
      end
      if (res_ch.valid && res_ch.ready) begin
        got_beat = res_ch.data;
        if (expected_readings.size() == 0) begin
          report_mismatch("result beat with no request waiting");
        end else begin
          want_beat = expected_readings.pop_front();
          compare_field("filtered_grams", got_beat.filtered_grams, want_beat.filtered_grams);
          compare_field("last_grams", got_beat.last_grams, want_beat.last_grams);
          compare_field("last_delta", got_beat.last_delta, want_beat.last_delta);
          compare_field("flow_active", 32'(got_beat.flow_active),
                        32'(want_beat.flow_active));
          compare_field("flow_detected", 32'(got_beat.flow_detected),
                        32'(want_beat.flow_detected));
          compare_field("flow_timed_out", 32'(got_beat.flow_timed_out),
                        32'(want_beat.flow_timed_out));
          compare_field("stale", 32'(got_beat.stale), 32'(want_beat.stale));
          compare_field("taring", 32'(got_beat.taring), 32'(want_beat.taring));
          compare_field("tare_done", 32'(got_beat.tare_done), 32'(want_beat.tare_done));
          compare_field("tare_offset", 32'(got_beat.tare_offset),
                        32'(want_beat.tare_offset));
        end
        beats_seen <= beats_seen + 1;
      end
      outstanding <= expected_readings.size();
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Top of the load-cell conditioner testbench: clock, reset, register writes and request
// stimulus with random idling on both channels; the verdict comes from sftfd_reading_checker.
// Depends on sftfd_pkg, the channel interfaces and scale_filter_tare_flow_detect.
module tb_top import sftfd_pkg::*; ();

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatch_count;
  int                    outstanding;

  bit          steady;
  logic [31:0] now_tb;
  longint      walk;
  int          cur_depth;
  logic [30:0] cur_thr;
  int          requests_sent;

  sftfd_req_if req_ch ();
  sftfd_res_if res_ch ();

  scale_filter_tare_flow_detect dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_ch    (req_ch),
    .res_ch    (res_ch)
  );

  sftfd_reading_checker reading_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .req_ch         (req_ch),
    .res_ch         (res_ch),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    res_ch.ready <= !rst && (steady || $urandom_range(99) >= 11);
  end

  function automatic req_t make_request(logic [1:0] kind, logic [31:0] now, logic ready,
                                        logic [23:0] raw, logic [31:0] grams);
    req_t r;
    r.req_type = kind;
    r.now_ms = now;
    r.sample_ready = ready;
    r.raw_sample = raw;
    r.grams_sample = grams;
    return r;
  endfunction

  function automatic logic [31:0] tick_time();
    int roll;
    roll = $urandom_range(99);
    if (roll < 85) now_tb += $urandom_range(300);
    else if (roll < 97) now_tb += $urandom_range(3000);
    else now_tb = $urandom;
    return now_tb;
  endfunction

  task automatic send_request(input req_t item);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 11) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= item;
    do @(posedge clk); while (!req_ch.ready);
    if (item.req_type != REQ_UNKNOWN) requests_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(input logic [31:0] depth, input logic [31:0] thr,
                                input logic [31:0] consec, input logic [31:0] fto,
                                input logic [31:0] sto, input logic [31:0] ok);
    set_register(CFG_FILTER_DEPTH, depth);
    set_register(CFG_FLOW_THRESHOLD, thr);
    set_register(CFG_FLOW_CONSECUTIVE, consec);
    set_register(CFG_FLOW_TIMEOUT, fto);
    set_register(CFG_STALE_TIMEOUT, sto);
    set_register(CFG_SENSOR_OK, ok);
    cur_depth = (depth[4:0] < 1) ? 1 : (depth[4:0] > MAX_DEPTH) ? MAX_DEPTH : int'(depth[4:0]);
    cur_thr = thr[30:0];
  endtask

  task automatic run_phase(input int count);
    int          goal;
    int          pick;
    longint      stepv;
    logic [31:0] grams;
    goal = requests_sent + count;
    while (requests_sent < goal) begin
      pick = $urandom_range(99);
      if (walk > 64'sd1000000000 || walk < -64'sd1000000000) walk = 0;
      if (pick < 35) begin
        send_request(make_request(REQ_FLOW, tick_time(), 1'($urandom), 24'($urandom),
                                  $urandom));
        repeat ($urandom_range(9, 2)) begin
          if ($urandom_range(99) < 70) stepv = longint'(cur_thr) + $urandom_range(400, 1);
          else stepv = longint'($urandom_range(600)) - 300;
          walk += stepv;
          send_request(make_request(REQ_TICK, tick_time(), $urandom_range(99) < 90,
                                    24'($urandom), walk[31:0]));
        end
      end else if (pick < 55) begin
        send_request(make_request(REQ_TARE, tick_time(), 1'($urandom), 24'($urandom),
                                  $urandom));
        repeat (cur_depth + $urandom_range(2) - 1) begin
          send_request(make_request(REQ_TICK, tick_time(), $urandom_range(99) < 85,
                                    24'($urandom), $urandom));
        end
      end else if (pick < 85) begin
        repeat ($urandom_range(6, 1)) begin
          walk += longint'($urandom_range(2000)) - 1000;
          grams = ($urandom_range(99) < 15) ? $urandom : walk[31:0];
          send_request(make_request(REQ_TICK, tick_time(), $urandom_range(99) < 80,
                                    24'($urandom), grams));
        end
      end else begin
        send_request(make_request(2'($urandom_range(3)),
                                  ($urandom_range(9) == 0) ? $urandom : tick_time(),
                                  1'($urandom), 24'($urandom), $urandom));
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    res_ch.ready = 1'b0;
    steady = 1'b0;
    now_tb = 32'd100;
    walk = 0;
    cur_depth = int'(RST_FILTER_DEPTH);
    cur_thr = RST_FLOW_THRESHOLD;
    requests_sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at reset settings: saturated deltas, flow found, flow timeout,
    // staleness across the time wrap, and a full tare with extreme raw readings.
    send_request(make_request(REQ_TICK, 32'd100, 1'b0, '0, '0));
    send_request(make_request(REQ_UNKNOWN, 32'd200, 1'b1, 24'h7FFFFF, 32'h7FFFFFFF));
    send_request(make_request(REQ_FLOW, 32'd300, 1'b0, '0, '0));
    send_request(make_request(REQ_TICK, 32'd400, 1'b1, '0, 32'h80000000));
    send_request(make_request(REQ_TICK, 32'd450, 1'b1, '0, 32'h7FFFFFFF));
    send_request(make_request(REQ_TICK, 32'd500, 1'b1, '0, 32'h80000000));
    send_request(make_request(REQ_TICK, 32'd550, 1'b1, '0, 32'd1000));
    send_request(make_request(REQ_TICK, 32'd600, 1'b1, '0, 32'd1300));
    send_request(make_request(REQ_TICK, 32'd650, 1'b1, '0, 32'd1557));
    send_request(make_request(REQ_FLOW, 32'd700, 1'b0, '0, '0));
    send_request(make_request(REQ_TICK, 32'd2699, 1'b0, '0, '0));
    send_request(make_request(REQ_TICK, 32'd2700, 1'b0, '0, '0));
    send_request(make_request(REQ_TICK, 32'hFFFFFF00, 1'b1, '0, -32'sd5));
    send_request(make_request(REQ_TICK, 32'h00000010, 1'b1, '0, -32'sd5));
    send_request(make_request(REQ_TARE, 32'h00000020, 1'b1, '0, '0));
    for (int i = 0; i < 11; i++) begin
      send_request(make_request(REQ_TICK, 32'h30 + 16 * i, i != 4,
                                i[0] ? 24'h7FFFFF : 24'h800000, 32'h7FFFFFFF));
    end
    now_tb = 32'h200;
    wait_idle();

    apply_settings(1, 0, 1, 0, 0, 1);
    run_phase(200);
    wait_idle();
    apply_settings(16, 32'h7FFFFFFF, 255, 32'hFFFFFFFF, 32'hFFFFFFFF, 1);
    run_phase(200);
    wait_idle();
    apply_settings(0, 0, 0, 300, 100, 1);
    run_phase(150);
    wait_idle();
    apply_settings(31, 100, 2, 1000, 400, 0);
    run_phase(100);
    wait_idle();
    for (int p = 0; p < 5; p++) begin
      apply_settings($urandom_range(16, 1), $urandom_range(1500), $urandom_range(5, 1),
                     $urandom_range(4000, 100), $urandom_range(1200, 50),
                     32'($urandom_range(9) != 0));
      steady = (p == 2);
      run_phase(220);
      wait_idle();
    end
    steady = 1'b0;
    repeat (60) @(negedge clk);

    if (mismatch_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
